// File: rtl/ptb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptb_pkg
// Shared types and constants for the palindromic tree builder.
// ----------------------------------------------------------------------------
package ptb_pkg;

  // Fixed widths of the item fields
  localparam int LETTER_W = 5;
  localparam int FIELD_W  = 13;

  typedef struct packed {
    logic [LETTER_W-1:0] letter;
    logic                restart;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] suffix_node;
    logic [FIELD_W-1:0] suffix_length;
    logic [FIELD_W-1:0] suffix_depth;
    logic               created;
    logic [FIELD_W-1:0] occurrences;
    logic               prefix_palindrome;
    logic               overflow;
  } out_item_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK_RD,
    ST_WALK_LEN,
    ST_WALK_CMP,
    ST_CH_RD,
    ST_CH_TAG,
    ST_TAG_CHK,
    ST_DEPTH,
    ST_NODE_RD,
    ST_NODE_FIN
  } state_t;

endpackage

// File: rtl/ptb_node_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptb_node_store
// Per-node records (length, suffix link, depth, hit count, parent and edge
// letter) with one registered read port; the two roots are supplied as fixed
// values so their entries never need initialising.
// ----------------------------------------------------------------------------
module ptb_node_store #(
  parameter int NODES  = 4098,
  parameter int NODE_W = 13,
  parameter int POS_W  = 13,
  parameter int LET_W  = 5
) (
  input  logic              clk,
  // read port, data registered behind the address
  input  logic [NODE_W-1:0] rd_addr,
  output logic [POS_W:0]    rd_len,
  output logic [NODE_W-1:0] rd_link,
  output logic [POS_W-1:0]  rd_depth,
  output logic [POS_W-1:0]  rd_hits,
  output logic [NODE_W-1:0] rd_parent,
  output logic [LET_W-1:0]  rd_label,
  // new node record
  input  logic              wr_node,
  input  logic [NODE_W-1:0] wr_addr,
  input  logic [POS_W-1:0]  wr_len,
  input  logic [NODE_W-1:0] wr_link,
  input  logic [POS_W-1:0]  wr_depth,
  input  logic [NODE_W-1:0] wr_parent,
  input  logic [LET_W-1:0]  wr_label,
  // hit counter
  input  logic              wr_hits_en,
  input  logic [NODE_W-1:0] wr_hits_addr,
  input  logic [POS_W-1:0]  wr_hits
);

  localparam logic [NODE_W-1:0] ROOT_EVEN = NODE_W'(0);
  localparam logic [NODE_W-1:0] ROOT_ODD  = NODE_W'(1);

  logic [POS_W-1:0]  len_mem    [NODES];
  logic [NODE_W-1:0] link_mem   [NODES];
  logic [POS_W-1:0]  depth_mem  [NODES];
  logic [POS_W-1:0]  hits_mem   [NODES];
  logic [NODE_W-1:0] parent_mem [NODES];
  logic [LET_W-1:0]  label_mem  [NODES];

  logic [NODE_W-1:0] addr_q;
  logic [POS_W-1:0]  len_q;
  logic [NODE_W-1:0] link_q;
  logic [POS_W-1:0]  depth_q;

  // record write
  always_ff @(posedge clk) begin
    if (wr_node) begin
      len_mem[wr_addr]    <= wr_len;
      link_mem[wr_addr]   <= wr_link;
      depth_mem[wr_addr]  <= wr_depth;
      parent_mem[wr_addr] <= wr_parent;
      label_mem[wr_addr]  <= wr_label;
    end
    if (wr_hits_en) begin
      hits_mem[wr_hits_addr] <= wr_hits;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    addr_q    <= rd_addr;
    len_q     <= len_mem[rd_addr];
    link_q    <= link_mem[rd_addr];
    depth_q   <= depth_mem[rd_addr];
    rd_hits   <= hits_mem[rd_addr];
    rd_parent <= parent_mem[rd_addr];
    rd_label  <= label_mem[rd_addr];
  end

  // roots: even root length 0 links to odd; odd root length -1 links to even
  always_comb begin
    if (addr_q == ROOT_EVEN) begin
      rd_len   = '0;
      rd_link  = ROOT_ODD;
      rd_depth = '0;
    end else if (addr_q == ROOT_ODD) begin
      rd_len   = '1;
      rd_link  = ROOT_EVEN;
      rd_depth = '0;
    end else begin
      rd_len   = {1'b0, len_q};
      rd_link  = link_q;
      rd_depth = depth_q;
    end
  end

endmodule

// File: rtl/palindromic_tree_builder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palindromic_tree_builder_top
// Incremental eertree over a letter stream: one result item per letter.
// ----------------------------------------------------------------------------
//  channel  | signals                               | role
//  ---------+---------------------------------------+----------------------
//  item     | item_valid, item_ready, item          | letter and restart in
//  result   | result_valid, result_ready, result    | longest suffix report
//
// A letter runs a first suffix-link walk (read, length check, text compare; a
// step rejected by the position check alone skips the compare), then the child
// lookup and the node read into the result register; creating a node adds a
// second walk. A dropped letter goes straight to the node read. item_ready is
// high only in the idle state. After reset a clearing pass over all NODES*ALPHABET
// child entries (106548 by default) zeroes the child table with item_ready low.
// A held result stalls the sequencer in its last state.
// ----------------------------------------------------------------------------
module palindromic_tree_builder_top #(
  parameter int MAX_LEN  = 4096,
  parameter int ALPHABET = 26
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  ptb_pkg::in_item_t    item,
  output logic                 result_valid,
  input  logic                 result_ready,
  output ptb_pkg::out_item_t   result
);

  localparam int NODES    = MAX_LEN + 2;
  localparam int NODE_W   = $clog2(NODES);
  localparam int CNT_W    = $clog2(NODES + 1);
  localparam int POS_W    = $clog2(MAX_LEN + 1);
  localparam int PW2      = POS_W + 2;
  localparam int LET_W    = (ALPHABET > 2) ? $clog2(ALPHABET) : 1;
  localparam int CH_DEPTH = NODES * ALPHABET;
  localparam int CH_W     = $clog2(CH_DEPTH);
  localparam int FW       = ptb_pkg::FIELD_W;

  localparam logic [CH_W-1:0]   ALPHA_C  = CH_W'(ALPHABET);
  localparam logic [CH_W-1:0]   CLR_LAST = CH_W'(CH_DEPTH - 1);
  localparam logic [8:0]        ALPHA_9  = 9'(ALPHABET);
  localparam logic [LET_W-1:0]  LET_MAX  = LET_W'(ALPHABET - 1);
  localparam logic [CNT_W-1:0]  CNT_TWO  = CNT_W'(2);
  localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(NODES);
  localparam logic [POS_W-1:0]  POS_FULL = POS_W'(MAX_LEN);
  localparam logic [NODE_W-1:0] ROOT_EVEN = NODE_W'(0);

  ptb_pkg::state_t state, state_next;

  // control and datapath registers
  logic [POS_W-1:0]  tl;
  logic [CNT_W-1:0]  nodes_used;
  logic [NODE_W-1:0] last;
  logic [NODE_W-1:0] x;
  logic [NODE_W-1:0] x_link;
  logic [POS_W:0]    x_len;
  logic              phase;
  logic [NODE_W-1:0] now;
  logic [POS_W:0]    now_len;
  logic [NODE_W-1:0] now_link;
  logic [CH_W-1:0]   slot;
  logic [CH_W-1:0]   ch_addr;
  logic [CH_W-1:0]   clr_addr;
  logic [NODE_W-1:0] sl;
  logic [POS_W-1:0]  new_len;
  logic [LET_W-1:0]  letter_q;
  logic              ovf;
  logic              created_q;

  // memories
  logic [LET_W-1:0]  text_mem  [MAX_LEN + 1];
  logic [NODE_W-1:0] child_mem [CH_DEPTH];
  logic [LET_W-1:0]  text_q;
  logic [NODE_W-1:0] ch_q;

  // node store port
  logic [NODE_W-1:0] nd_addr;
  logic [POS_W:0]    nd_len;
  logic [NODE_W-1:0] nd_link;
  logic [POS_W-1:0]  nd_depth;
  logic [POS_W-1:0]  nd_hits;
  logic [NODE_W-1:0] nd_parent;
  logic [LET_W-1:0]  nd_label;
  logic              nd_wr;
  logic              hits_wr;
  logic [NODE_W-1:0] hits_addr;
  logic [POS_W-1:0]  hits_val;
  logic [NODE_W-1:0] new_id;

  // combinational helpers
  logic              accept;
  logic              fin_go;
  logic [8:0]        let_ext;
  logic [LET_W-1:0]  let_sat;
  logic [POS_W-1:0]  tl_eff;
  logic [NODE_W-1:0] last_eff;
  logic              full_eff;
  logic [PW2-1:0]    walk_pos;
  logic              walk_ok;
  logic              len_neg;
  logic              text_hit;
  logic              tag_ok;
  logic              can_grow;
  logic [POS_W-1:0]  hits_inc;
  logic [POS_W:0]    len_plus2;

  assign accept   = item_valid && item_ready;
  assign fin_go   = !result_valid || result_ready;
  assign new_id   = NODE_W'(nodes_used);
  assign can_grow = nodes_used < CNT_FULL;

  // letter saturation and restart view
  always_comb begin
    let_ext  = 9'(item.letter);
    let_sat  = (let_ext >= ALPHA_9) ? LET_MAX : LET_W'(let_ext);
    tl_eff   = item.restart ? '0 : tl;
    last_eff = item.restart ? ROOT_EVEN : last;
    full_eff = tl_eff >= POS_FULL;
  end

  // walk step: position of the letter before the candidate palindrome
  always_comb begin
    walk_pos  = PW2'(tl) - PW2'(nd_len) - PW2'(1);
    walk_ok   = !walk_pos[PW2-1] && (walk_pos != '0);
    len_neg   = nd_len[POS_W];
    text_hit  = text_q == letter_q;
    tag_ok    = (ch_q >= NODE_W'(2)) && (CNT_W'(ch_q) < nodes_used)
                && (nd_parent == x) && (nd_label == letter_q);
    hits_inc  = nd_hits + POS_W'(1);
    len_plus2 = now_len + (POS_W + 1)'(2);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ptb_pkg::ST_CLEAR: begin
        if (clr_addr == CLR_LAST) state_next = ptb_pkg::ST_IDLE;
      end
      ptb_pkg::ST_IDLE: begin
        if (accept) state_next = full_eff ? ptb_pkg::ST_NODE_RD : ptb_pkg::ST_WALK_RD;
      end
      ptb_pkg::ST_WALK_RD:  state_next = ptb_pkg::ST_WALK_LEN;
      ptb_pkg::ST_WALK_LEN: begin
        if (len_neg)      state_next = ptb_pkg::ST_CH_RD;
        else if (walk_ok) state_next = ptb_pkg::ST_WALK_CMP;
        else              state_next = ptb_pkg::ST_WALK_RD;
      end
      ptb_pkg::ST_WALK_CMP: begin
        state_next = text_hit ? ptb_pkg::ST_CH_RD : ptb_pkg::ST_WALK_RD;
      end
      ptb_pkg::ST_CH_RD:  state_next = ptb_pkg::ST_CH_TAG;
      ptb_pkg::ST_CH_TAG: state_next = ptb_pkg::ST_TAG_CHK;
      ptb_pkg::ST_TAG_CHK: begin
        if (phase)                  state_next = ptb_pkg::ST_DEPTH;
        else if (tag_ok)            state_next = ptb_pkg::ST_NODE_RD;
        else if (can_grow)          state_next = ptb_pkg::ST_WALK_RD;
        else                        state_next = ptb_pkg::ST_NODE_RD;
      end
      ptb_pkg::ST_DEPTH:   state_next = ptb_pkg::ST_NODE_RD;
      ptb_pkg::ST_NODE_RD: state_next = ptb_pkg::ST_NODE_FIN;
      ptb_pkg::ST_NODE_FIN: begin
        if (fin_go) state_next = ptb_pkg::ST_IDLE;
      end
      default: state_next = ptb_pkg::ST_IDLE;
    endcase
  end

  // outputs to the handshake and the node store
  always_comb begin
    item_ready = state == ptb_pkg::ST_IDLE;
    nd_addr    = x;
    nd_wr      = 1'b0;
    hits_wr    = 1'b0;
    hits_addr  = last;
    hits_val   = hits_inc;
    unique case (state)
      ptb_pkg::ST_CH_TAG:  nd_addr = ch_q;
      ptb_pkg::ST_TAG_CHK: nd_addr = tag_ok ? ch_q : ROOT_EVEN;
      ptb_pkg::ST_DEPTH: begin
        nd_wr     = 1'b1;
        hits_wr   = 1'b1;
        hits_addr = new_id;
        hits_val  = '0;
      end
      ptb_pkg::ST_NODE_RD:  nd_addr = last;
      ptb_pkg::ST_NODE_FIN: begin
        nd_addr = last;
        hits_wr = fin_go && !ovf;
      end
      default: nd_addr = x;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ptb_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // child table clearing counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == ptb_pkg::ST_CLEAR) begin
      clr_addr <= clr_addr + CH_W'(1);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tl           <= '0;
      nodes_used   <= CNT_TWO;
      last         <= ROOT_EVEN;
      result_valid <= 1'b0;
    end else begin
      if (state == ptb_pkg::ST_NODE_FIN && fin_go) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ptb_pkg::ST_IDLE: begin
          if (accept) begin
            if (item.restart) nodes_used <= CNT_TWO;
            last <= last_eff;
            tl   <= full_eff ? tl_eff : tl_eff + POS_W'(1);
          end
        end
        ptb_pkg::ST_TAG_CHK: begin
          if (!phase && tag_ok) last <= ch_q;
        end
        ptb_pkg::ST_DEPTH: begin
          last       <= new_id;
          nodes_used <= nodes_used + CNT_W'(1);
        end
        default: ;
      endcase
    end
  end

  // walk datapath
  always_ff @(posedge clk) begin
    case (state)
      ptb_pkg::ST_IDLE: begin
        letter_q  <= let_sat;
        x         <= last_eff;
        phase     <= 1'b0;
        ovf       <= full_eff;
        created_q <= 1'b0;
      end
      ptb_pkg::ST_WALK_LEN: begin
        x_link <= nd_link;
        x_len  <= nd_len;
        if (len_neg) begin
          now      <= x;
          now_len  <= nd_len;
          now_link <= nd_link;
          ch_addr  <= CH_W'(x) * ALPHA_C + CH_W'(letter_q);
          if (!phase) slot <= CH_W'(x) * ALPHA_C + CH_W'(letter_q);
        end else if (!walk_ok) begin
          x <= nd_link;
        end
      end
      ptb_pkg::ST_WALK_CMP: begin
        if (text_hit) begin
          now      <= x;
          now_len  <= x_len;
          now_link <= x_link;
          ch_addr  <= CH_W'(x) * ALPHA_C + CH_W'(letter_q);
          if (!phase) slot <= CH_W'(x) * ALPHA_C + CH_W'(letter_q);
        end else begin
          x <= x_link;
        end
      end
      ptb_pkg::ST_TAG_CHK: begin
        if (phase) begin
          sl <= tag_ok ? ch_q : ROOT_EVEN;
        end else if (!tag_ok && can_grow) begin
          phase   <= 1'b1;
          new_len <= POS_W'(len_plus2);
          x       <= now_link;
        end
      end
      ptb_pkg::ST_DEPTH: created_q <= 1'b1;
      default: ;
    endcase
  end

  // phase one keeps the first match in now; parent is that node
  // (x is overwritten by the second walk, so the record takes the saved slot's node)
  logic [NODE_W-1:0] parent_id;
  always_ff @(posedge clk) begin
    if (state == ptb_pkg::ST_TAG_CHK && !phase) parent_id <= now;
  end

  // text memory
  always_ff @(posedge clk) begin
    if (accept && !full_eff) text_mem[tl_eff + POS_W'(1)] <= let_sat;
    text_q <= text_mem[walk_pos[POS_W-1:0]];
  end

  // child table; zeroed once after reset, stale entries from earlier strings
  // are rejected by the parent and letter tag
  always_ff @(posedge clk) begin
    if (state == ptb_pkg::ST_CLEAR) begin
      child_mem[clr_addr] <= '0;
    end else if (state == ptb_pkg::ST_DEPTH) begin
      child_mem[slot] <= new_id;
    end
    ch_q <= child_mem[ch_addr];
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == ptb_pkg::ST_NODE_FIN && fin_go) begin
      result.suffix_node       <= FW'(last);
      result.suffix_length     <= nd_len[POS_W] ? '0 : FW'(nd_len[POS_W-1:0]);
      result.suffix_depth      <= FW'(nd_depth);
      result.created           <= created_q;
      result.occurrences       <= ovf ? FW'(nd_hits) : FW'(hits_inc);
      result.prefix_palindrome <= !nd_len[POS_W] && (nd_len[POS_W-1:0] == tl);
      result.overflow          <= ovf;
    end
  end

  ptb_node_store #(
    .NODES  (NODES),
    .NODE_W (NODE_W),
    .POS_W  (POS_W),
    .LET_W  (LET_W)
  ) u_nodes (
    .clk          (clk),
    .rd_addr      (nd_addr),
    .rd_len       (nd_len),
    .rd_link      (nd_link),
    .rd_depth     (nd_depth),
    .rd_hits      (nd_hits),
    .rd_parent    (nd_parent),
    .rd_label     (nd_label),
    .wr_node      (nd_wr),
    .wr_addr      (new_id),
    .wr_len       (new_len),
    .wr_link      (sl),
    .wr_depth     (nd_depth + POS_W'(1)),
    .wr_parent    (parent_id),
    .wr_label     (letter_q),
    .wr_hits_en   (hits_wr),
    .wr_hits_addr (hits_addr),
    .wr_hits      (hits_val)
  );

`ifndef SYNTHESIS
  // node count stays within the two roots and the store size
  a_nodes_range: assert property (@(posedge clk) disable iff (rst)
    nodes_used >= CNT_TWO && nodes_used <= CNT_FULL)
    else $error("node count out of range");

  // a creation step adds exactly one node
  a_create_adds: assert property (@(posedge clk) disable iff (rst)
    state == ptb_pkg::ST_DEPTH |=> nodes_used == $past(nodes_used) + CNT_W'(1))
    else $error("node creation did not advance the count");

  // text length never exceeds the limit
  a_text_range: assert property (@(posedge clk) disable iff (rst)
    tl <= POS_FULL)
    else $error("text length beyond limit");

  // a letter taken without restart on a non-full string extends the text
  a_text_grows: assert property (@(posedge clk) disable iff (rst)
    accept && !item.restart && !full_eff |=> tl == $past(tl) + POS_W'(1))
    else $error("accepted letter did not extend the text");
`endif

endmodule

// File: test/palindromic_tree_builder_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palindromic_tree_builder_top_test
// Self-checking bench for the eertree builder: feeds letter streams with
// restarts, predicts every result item from an own eertree model and checks
// each field. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module palindromic_tree_builder_top_test;

  localparam int MAX_LEN  = 4096;
  localparam int ALPHABET = 26;
  localparam int NODES    = MAX_LEN + 2;
  localparam int FW       = ptb_pkg::FIELD_W;

  // Eertree predictor and queue of expected result items
  class eertree_scoreboard;
    bit [4:0]   text[MAX_LEN+1];
    int         node_len[NODES];
    int         link[NODES];
    int         child[NODES*ALPHABET];
    int         depth[NODES];
    int         hits[NODES];
    int         last;
    int         used;
    int         tlen;
    ptb_pkg::out_item_t pending[$];
    int         mismatches;
    int         checked;
    int         created_seen;
    int         overflow_seen;

    function void init_node(int id, int len);
      for (int i = 0; i < ALPHABET; i++) child[id*ALPHABET+i] = 0;
      node_len[id] = len;
      link[id]     = 0;
      depth[id]    = 0;
      hits[id]     = 0;
    endfunction

    function void clear();
      used = 2;
      tlen = 0;
      last = 0;
      init_node(0, 0);
      init_node(1, -1);
      link[0] = 1;
      link[1] = 0;
    endfunction

    function int walk(int x);
      int p;
      for (int g = 0; g <= NODES; g++) begin
        if (x >= NODES) return 1;
        if (node_len[x] < 0) return x;
        p = tlen - node_len[x] - 1;
        if (p >= 1 && p <= tlen && text[p] == text[tlen]) return x;
        x = link[x];
      end
      return 1;
    endfunction

    // Note an accepted input item and queue its expected result
    function void note_item(ptb_pkg::in_item_t it);
      int        ltr;
      int        now;
      int        slot;
      int        id;
      int        f;
      int        len;
      ptb_pkg::out_item_t exp_r;
      ltr = int'(it.letter);
      exp_r = '0;
      if (ltr >= ALPHABET) ltr = ALPHABET - 1;
      if (it.restart) clear();
      if (tlen >= MAX_LEN) begin
        exp_r.overflow = 1'b1;
      end else begin
        tlen++;
        text[tlen] = 5'(ltr);
        now  = walk(last);
        slot = now*ALPHABET + ltr;
        if (child[slot] == 0 && used < NODES) begin
          id = used++;
          init_node(id, node_len[now] + 2);
          f = walk(link[now]);
          link[id]  = child[f*ALPHABET + ltr];
          depth[id] = depth[link[id]] + 1;
          child[slot] = id;
          exp_r.created = 1'b1;
        end
        if (child[slot] != 0) last = child[slot];
        hits[last]++;
      end
      len = node_len[last];
      exp_r.suffix_node       = FW'(last);
      exp_r.suffix_length     = (len < 0) ? '0 : FW'(len);
      exp_r.suffix_depth      = FW'(depth[last]);
      exp_r.occurrences       = FW'(hits[last]);
      exp_r.prefix_palindrome = (len >= 0 && len == tlen);
      pending.push_back(exp_r);
    endfunction

    // Compare an accepted result with the oldest expectation
    function void check_result(ptb_pkg::out_item_t got);
      ptb_pkg::out_item_t e;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %p", got);
        return;
      end
      e = pending.pop_front();
      if (got.created) created_seen++;
      if (got.overflow) overflow_seen++;
      if (got !== e) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch at result %0d: expected %p, got %p", checked, e, got);
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      item_valid = 1'b0;
  logic      item_ready;
  ptb_pkg::in_item_t  item = '0;
  logic      result_valid;
  logic      result_ready = 1'b0;
  ptb_pkg::out_item_t result;

  eertree_scoreboard sb = new();
  int  idle_pct = 16;
  int  items_sent;
  bit  stim_done;

  palindromic_tree_builder_top #(.MAX_LEN(MAX_LEN), .ALPHABET(ALPHABET)) u_top (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result)
  );

  always #5 clk = ~clk;

  // Monitor both channels at each edge
  always @(posedge clk) begin
    if (!rst && item_valid && item_ready) sb.note_item(item);
    if (!rst && result_valid && result_ready) sb.check_result(result);
  end

  // Random result stalls
  always @(posedge clk) begin
    if (rst) result_ready <= 1'b0;
    else result_ready <= ($urandom_range(99) >= idle_pct);
  end

  // Send one item, idling beforehand at random
  task automatic send_letter(input int ltr, input bit rs);
    while ($urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid   <= 1'b1;
    item.letter  <= ltr[4:0];
    item.restart <= rs;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    items_sent++;
  endtask

  // Random string over the given alphabet size, often mirrored to build palindromes
  task automatic send_string(input int n, input int alpha);
    int s[$];
    int k;
    for (int i = 0; i < n; i++) begin
      if (s.size() > 2 && $urandom_range(2) == 0) begin
        k = $urandom_range(s.size()-1);
        s.push_back(s[k]);
      end else begin
        s.push_back($urandom_range(alpha-1));
      end
    end
    if ($urandom_range(1)) for (int i = n-1; i >= 0; i--) s.push_back(s[i]);
    foreach (s[i]) send_letter(s[i], i == 0);
  endtask

  initial begin
    int n;
    sb.clear();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, out-of-range letters, palindromes, restarts
    send_letter(0, 1'b1);
    send_letter(0, 1'b0);
    send_letter(0, 1'b0);
    send_letter(25, 1'b0);
    send_letter(0, 1'b0);
    send_letter(0, 1'b0);
    send_letter(31, 1'b0);
    send_letter(26, 1'b0);
    send_letter(25, 1'b0);
    send_letter(21, 1'b1);
    send_letter(10, 1'b0);
    send_letter(21, 1'b0);
    send_letter(10, 1'b0);
    send_letter(31, 1'b1);
    send_letter(16, 1'b0);
    send_letter(1, 1'b0);
    send_letter(2, 1'b0);
    send_letter(1, 1'b0);
    send_letter(16, 1'b0);

    // Random strings; a no-idle stretch in the middle
    while (items_sent < 900) begin
      n = $urandom_range(1, 30);
      send_string(n, ($urandom_range(3) == 0) ? 32 : $urandom_range(2, 4));
    end
    idle_pct = 0;
    while (items_sent < 1200) send_string($urandom_range(1, 30), $urandom_range(2, 3));
    idle_pct = 16;

    // One long two-letter string for deep suffix-link walks
    send_letter($urandom_range(31), 1'b1);
    for (int i = 1; i < 240; i++) send_letter($urandom_range(1), 1'b0);
    while (items_sent < 1700)
      send_string($urandom_range(1, 30), $urandom_range(2, 26));
    item_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // End of run
  initial begin
    wait (stim_done);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("sent %0d letters, checked %0d results (%0d new nodes, %0d overflows)",
             items_sent, sb.checked, sb.created_seen, sb.overflow_seen);
    if (sb.mismatches == 0) begin
      $display("** palindromic_tree_builder_top: PASSED **");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("** palindromic_tree_builder_top: FAILED **");
    end
    $finish;
  end

  // Timeout
  initial begin
    #40ms;
    $display("timeout with %0d results outstanding", sb.pending.size());
    $display("** palindromic_tree_builder_top: FAILED **");
    $finish;
  end

endmodule
